// ===== rtl/core/b64d_pkg.sv =====
`timescale 1ns / 1ps

package b64d_pkg;

    localparam int unsigned CHAR_W   = 8;
    localparam int unsigned SEXTET_W = 6;
    localparam int unsigned ACC_W    = 12;
    localparam int unsigned STATUS_W = 3;

    localparam logic [CHAR_W-1:0] CHAR_PAD = 8'h3D;  // '='

    localparam logic [STATUS_W-1:0] STATUS_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_LEN_ERR   = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_CHAR_ERR  = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_PAD_ERR   = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_NO_OUTPUT = 3'd4;

    // one accepted character
    typedef struct packed {
        logic [CHAR_W-1:0] char_in;
        logic              last;
    } b64d_item_t;

    // one result item
    typedef struct packed {
        logic [CHAR_W-1:0]   data_byte;
        logic                byte_valid;
        logic                done_res;
        logic [STATUS_W-1:0] status;
    } b64d_result_t;

    // alphabet lookup: bit 6 set when the character is outside the alphabet
    function automatic logic [SEXTET_W:0] b64d_sextet(input logic [CHAR_W-1:0] ch);
        logic [SEXTET_W:0] v;
        v = 7'h40;
        if (ch >= 8'h41 && ch <= 8'h5A) begin
            v = 7'(ch - 8'h41);
        end
        else if (ch >= 8'h61 && ch <= 8'h7A) begin
            v = 7'(ch - 8'h61 + 8'd26);
        end
        else if (ch >= 8'h30 && ch <= 8'h39) begin
            v = 7'(ch - 8'h30 + 8'd52);
        end
        else if (ch == 8'h2B) begin
            v = 7'd62;
        end
        else if (ch == 8'h2F) begin
            v = 7'd63;
        end
        return v;
    endfunction

endpackage

// ===== rtl/core/base64_stream_decoder.sv =====
`timescale 1ns / 1ps

// channel   | direction | tdata                      | tuser      | tlast
// ----------+-----------+----------------------------+------------+---------
// s_axis    | in        | [7:0] char_in              | -          | last
// m_axis    | out       | [7:0] data_byte,[10:8] status | byte_valid | done_res
//
// one character per cycle sustained while m_axis does not stall; each character passes
// through the input register and its result through the output register
// characters that produce no byte and are not last leave no transfer on m_axis
// rst_n clears the decoder state and both stage valid flags, no clearing pass
// a stall on m_axis holds the output register; the input register keeps taking
// characters that produce no result, and stalls s_axis only on one that does

module base64_stream_decoder
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_in
    input  logic        s_axis_tlast,   // last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] data_byte, [10:8] status, rest zero
    output logic        m_axis_tuser,   // byte_valid
    output logic        m_axis_tlast    // done_res
);
    import b64d_pkg::*;

    b64d_item_t   in_item;
    b64d_item_t   item;
    logic         item_valid;
    logic         take;
    logic         load;
    logic         out_free;
    b64d_result_t result;
    b64d_result_t out_result;

    assign in_item.char_in = s_axis_tdata;
    assign in_item.last    = s_axis_tlast;

    b64d_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_item    (in_item),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    // alphabet lookup, bit gathering and end-of-message checks
    b64d_step u_step
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .out_free   (out_free),
        .take       (take),
        .load       (load),
        .result     (result)
    );

    b64d_out_stage u_out_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (load),
        .result     (result),
        .out_free   (out_free),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_result (out_result)
    );

    assign m_axis_tdata = {5'd0, out_result.status, out_result.data_byte};
    assign m_axis_tuser = out_result.byte_valid;
    assign m_axis_tlast = out_result.done_res;

endmodule

// ===== rtl/core/b64d_in_stage.sv =====
`timescale 1ns / 1ps

module b64d_in_stage
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  b64d_pkg::b64d_item_t in_item,
    input  logic                take,
    output logic                item_valid,
    output b64d_pkg::b64d_item_t item
);
    import b64d_pkg::*;

    logic       valid_reg;
    b64d_item_t item_reg;

    // refill when empty or when the held character moves on this cycle
    assign in_ready   = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_item;
        end
    end

endmodule

// ===== rtl/core/b64d_step.sv =====
`timescale 1ns / 1ps

module b64d_step
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    input  b64d_pkg::b64d_item_t  item,
    input  logic                  out_free,
    output logic                  take,
    output logic                  load,
    output b64d_pkg::b64d_result_t result
);
    import b64d_pkg::*;

    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [2:0]       pending_reg, pending_next;
    logic [1:0]       phase_reg, phase_next;
    logic             pad_seen_reg, pad_seen_next;
    logic [1:0]       pad_run_reg, pad_run_next;
    logic             junk_reg, junk_next;
    logic             char_err_reg, char_err_next;
    logic             any_out_reg, any_out_next;

    logic [SEXTET_W:0] sextet;
    logic [3:0]        bits_sum;
    logic              need_result;
    logic              is_pad;

    assign sextet = b64d_sextet(item.char_in);
    assign is_pad = (item.char_in == CHAR_PAD);

    always_comb
    begin
        acc_next      = acc_reg;
        pending_next  = pending_reg;
        phase_next    = phase_reg + 2'd1;
        pad_seen_next = pad_seen_reg;
        pad_run_next  = pad_run_reg;
        junk_next     = junk_reg;
        char_err_next = char_err_reg;
        any_out_next  = any_out_reg;
        bits_sum      = {1'b0, pending_reg} + 4'd6;

        result            = '0;
        result.done_res   = item.last;

        if (pad_seen_reg)
        begin
            if (pad_run_reg != 2'd3)
            begin
                pad_run_next = pad_run_reg + 2'd1;
            end
            if (!is_pad)
            begin
                junk_next = 1'b1;
            end
        end
        else if (is_pad)
        begin
            pad_seen_next = 1'b1;
            pad_run_next  = 2'd1;
        end
        else if (!char_err_reg)
        begin
            if (sextet[SEXTET_W])
            begin
                char_err_next = 1'b1;
            end
            else
            begin
                acc_next = {acc_reg[ACC_W-SEXTET_W-1:0], sextet[SEXTET_W-1:0]};
                if (bits_sum >= 4'd8)
                begin
                    pending_next      = 3'(bits_sum - 4'd8);
                    result.byte_valid = 1'b1;
                    any_out_next      = 1'b1;
                    case (pending_next)
                        3'd0:    result.data_byte = acc_next[7:0];
                        3'd2:    result.data_byte = acc_next[9:2];
                        3'd4:    result.data_byte = acc_next[11:4];
                        default: result.data_byte = acc_next[7:0];
                    endcase
                end
                else
                begin
                    pending_next = bits_sum[2:0];
                end
            end
        end

        if (item.last)
        begin
            // status in priority order, then clear for the next message
            if (phase_next == 2'd1)
            begin
                result.status = STATUS_LEN_ERR;
            end
            else if (char_err_next)
            begin
                result.status = STATUS_CHAR_ERR;
            end
            else if (pad_seen_next && (pad_run_next == 2'd3 || junk_next))
            begin
                result.status = STATUS_PAD_ERR;
            end
            else if (!any_out_next)
            begin
                result.status = STATUS_NO_OUTPUT;
            end
            else
            begin
                result.status = STATUS_OK;
            end
            acc_next      = '0;
            pending_next  = '0;
            phase_next    = '0;
            pad_seen_next = 1'b0;
            pad_run_next  = '0;
            junk_next     = 1'b0;
            char_err_next = 1'b0;
            any_out_next  = 1'b0;
        end
    end

    assign need_result = result.byte_valid || item.last;
    assign take        = item_valid && (!need_result || out_free);
    assign load        = take && need_result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg      <= '0;
            pending_reg  <= '0;
            phase_reg    <= '0;
            pad_seen_reg <= 1'b0;
            pad_run_reg  <= '0;
            junk_reg     <= 1'b0;
            char_err_reg <= 1'b0;
            any_out_reg  <= 1'b0;
        end
        else if (take)
        begin
            acc_reg      <= acc_next;
            pending_reg  <= pending_next;
            phase_reg    <= phase_next;
            pad_seen_reg <= pad_seen_next;
            pad_run_reg  <= pad_run_next;
            junk_reg     <= junk_next;
            char_err_reg <= char_err_next;
            any_out_reg  <= any_out_next;
        end
    end

endmodule

// ===== rtl/core/b64d_out_stage.sv =====
`timescale 1ns / 1ps

module b64d_out_stage
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  b64d_pkg::b64d_result_t result,
    output logic                   out_free,
    output logic                   out_valid,
    input  logic                   out_ready,
    output b64d_pkg::b64d_result_t out_result
);
    import b64d_pkg::*;

    logic         valid_reg;
    b64d_result_t result_reg;

    assign out_free   = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign out_result = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

// tracks the decoder state for each accepted character and holds the
// results that the decoder still owes
class b64_scoreboard;
    logic [11:0] acc_bits;
    logic [2:0]  held_bits;
    logic [1:0]  char_phase;
    logic [1:0]  pad_count;
    bit          pad_found;
    bit          pad_junk;
    bit          bad_char;
    bit          byte_made;

    b64d_pkg::b64d_result_t due_results[$];

    int errors;
    int chars_seen;
    int bytes_seen;
    int messages;
    int status_seen[5];

    function new();
        clear_message();
    endfunction

    function void clear_message();
        acc_bits   = '0;
        held_bits  = '0;
        char_phase = '0;
        pad_count  = '0;
        pad_found  = 0;
        pad_junk   = 0;
        bad_char   = 0;
        byte_made  = 0;
    endfunction

    // one accepted character: update the state, queue a result if one is due
    function void note_char(logic [7:0] ch, logic lst);
        b64d_pkg::b64d_result_t r;
        logic [6:0] v;
        logic [3:0] n;
        bit         emit;
        emit = 0;
        r = '0;
        chars_seen++;
        char_phase = char_phase + 2'd1;
        if (pad_found)
        begin
            if (pad_count != 2'd3)
                pad_count = pad_count + 2'd1;
            if (ch != b64d_pkg::CHAR_PAD)
                pad_junk = 1;
        end
        else if (ch == b64d_pkg::CHAR_PAD)
        begin
            pad_found = 1;
            pad_count = 2'd1;
        end
        else if (!bad_char)
        begin
            v = 7'd64;
            if (ch >= "A" && ch <= "Z")
                v = 7'(ch - "A");
            else if (ch >= "a" && ch <= "z")
                v = 7'(ch - "a" + 26);
            else if (ch >= "0" && ch <= "9")
                v = 7'(ch - "0" + 52);
            else if (ch == "+")
                v = 7'd62;
            else if (ch == "/")
                v = 7'd63;
            if (v[6])
                bad_char = 1;
            else
            begin
                n = 4'(held_bits) + 4'd6;
                acc_bits = {acc_bits[5:0], v[5:0]};
                if (n >= 4'd8)
                begin
                    n = n - 4'd8;
                    r.data_byte = 8'(acc_bits >> n);
                    emit = 1;
                    byte_made = 1;
                    bytes_seen++;
                end
                held_bits = n[2:0];
            end
        end
        if (emit || lst)
        begin
            r.byte_valid = emit;
            r.done_res = lst;
            if (lst)
            begin
                if (char_phase == 2'd1)
                    r.status = b64d_pkg::STATUS_LEN_ERR;
                else if (bad_char)
                    r.status = b64d_pkg::STATUS_CHAR_ERR;
                else if (pad_found && (pad_count == 2'd3 || pad_junk))
                    r.status = b64d_pkg::STATUS_PAD_ERR;
                else if (!byte_made)
                    r.status = b64d_pkg::STATUS_NO_OUTPUT;
                else
                    r.status = b64d_pkg::STATUS_OK;
                status_seen[r.status]++;
                messages++;
                clear_message();
            end
            due_results.insert(due_results.size(), r);
        end
    endfunction

    // one result transfer against the oldest owed result
    function void check_output(logic [15:0] tdata, logic tuser, logic tlast);
        b64d_pkg::b64d_result_t want;
        if (due_results.size() == 0)
        begin
            $display("%0t: unexpected result tdata %04h tuser %0b tlast %0b",
                     $time, tdata, tuser, tlast);
            errors++;
        end
        else
        begin
            want = due_results.pop_front();
            if (tdata[7:0] !== want.data_byte)
            begin
                $display("%0t: data_byte expected %02h actual %02h",
                         $time, want.data_byte, tdata[7:0]);
                errors++;
            end
            if (tdata[10:8] !== want.status)
            begin
                $display("%0t: status expected %0d actual %0d",
                         $time, want.status, tdata[10:8]);
                errors++;
            end
            if (tuser !== want.byte_valid)
            begin
                $display("%0t: byte_valid expected %0b actual %0b",
                         $time, want.byte_valid, tuser);
                errors++;
            end
            if (tlast !== want.done_res)
            begin
                $display("%0t: done_res expected %0b actual %0b",
                         $time, want.done_res, tlast);
                errors++;
            end
        end
    endfunction
endclass

module tb_top;
    import b64d_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    // percent of cycles the sender holds back and the receiver stalls
    int idle_pct;
    int stall_pct;

    // characters of the message about to be sent
    logic [7:0] msg_chars[$];

    b64_scoreboard sb;

    base64_stream_decoder uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    // receiver side: random stalls at the current rate
    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    // both handshakes are sampled with the values from before the edge
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            sb.note_char(s_axis_tdata, s_axis_tlast);
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_output(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end

    // one character transfer, with random idle cycles ahead of it
    task automatic send_char(input logic [7:0] ch, input logic lst);
        while ($urandom_range(99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        s_axis_tlast  <= lst;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // the whole of msg_chars, last flag on the final character
    task automatic send_message();
        for (int i = 0; i < msg_chars.size(); i++)
            send_char(msg_chars[i], i == msg_chars.size() - 1);
    endtask

    task automatic send_text(input string s);
        msg_chars.delete();
        for (int i = 0; i < s.len(); i++)
            msg_chars.insert(msg_chars.size(), s[i]);
        send_message();
    endtask

    function automatic logic [7:0] alphabet_char(input int v);
        if (v < 26)
            return 8'("A" + v);
        else if (v < 52)
            return 8'("a" + v - 26);
        else if (v < 62)
            return 8'("0" + v - 52);
        else if (v == 62)
            return "+";
        else
            return "/";
    endfunction

    // mostly well-formed messages with random content, some broken by one
    // mutation, the rest plain noise over the full character range
    task automatic build_random_message();
        int kind;
        int groups;
        int pads;
        int pos;
        kind = $urandom_range(99);
        msg_chars.delete();
        if (kind < 85)
        begin
            groups = ($urandom_range(9) == 0) ? $urandom_range(16, 5) : $urandom_range(3, 1);
            for (int i = 0; i < 4 * groups; i++)
                msg_chars.insert(msg_chars.size(), alphabet_char($urandom_range(63)));
            pads = $urandom_range(2);
            for (int i = 0; i < pads; i++)
                msg_chars[msg_chars.size() - 1 - i] = CHAR_PAD;
            if (kind >= 65)
            begin
                pos = $urandom_range(msg_chars.size() - 1);
                case ($urandom_range(3))
                    0: msg_chars.insert(pos, 8'($urandom_range(255)));
                    1: msg_chars.delete(pos);
                    2: msg_chars.insert(msg_chars.size(), CHAR_PAD);
                    default: msg_chars.insert(msg_chars.size(),
                                              alphabet_char($urandom_range(63)));
                endcase
                if (msg_chars.size() == 0)
                    msg_chars.insert(msg_chars.size(), CHAR_PAD);
            end
        end
        else
        begin
            groups = $urandom_range(10, 1);
            for (int i = 0; i < groups; i++)
                msg_chars.insert(msg_chars.size(), 8'($urandom_range(255)));
        end
    endtask

    task automatic run_phase(input int n_chars, input int idle, input int stall);
        int sent;
        idle_pct  = idle;
        stall_pct = stall;
        sent = 0;
        while (sent < n_chars)
        begin
            build_random_message();
            sent += msg_chars.size();
            send_message();
        end
    endtask

    // hard stop well beyond the slowest correct run
    initial
    begin
        #2000000;
        $display("base64_stream_decoder test failed");
        $finish;
    end

    initial
    begin
        sb = new();
        idle_pct      = 0;
        stall_pct     = 0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: clean groups, one and two pads, each error status
        send_text("TWFu");
        send_text("TQ==");
        send_text("A");              // length error
        send_text("A==");            // nothing decoded
        msg_chars = {8'h2B, 8'h2F, 8'h39, 8'h00};
        send_message();              // bytes, then an out-of-alphabet code
        msg_chars = {8'hFF, 8'h51};
        send_message();              // non-ascii at the start
        send_text("TQ=x");           // junk behind the pad
        send_text("TWE===");         // too many pad characters

        // random: no idling, sender idle, receiver stalled, both
        run_phase(460, 0, 0);
        run_phase(460, 77, 0);
        run_phase(460, 0, 77);
        run_phase(460, 16, 16);

        s_axis_tvalid <= 1'b0;
        while (sb.due_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("covered %0d characters in %0d messages, %0d bytes decoded",
                 sb.chars_seen, sb.messages, sb.bytes_seen);
        $display("final status counts ok %0d length %0d char %0d pad %0d empty %0d",
                 sb.status_seen[STATUS_OK], sb.status_seen[STATUS_LEN_ERR],
                 sb.status_seen[STATUS_CHAR_ERR], sb.status_seen[STATUS_PAD_ERR],
                 sb.status_seen[STATUS_NO_OUTPUT]);
        if (sb.errors == 0)
            $display("base64_stream_decoder test passed");
        else
            $display("base64_stream_decoder test failed");
        $finish;
    end

endmodule

// ===== base64_stream_decoder.f =====
rtl/core/b64d_pkg.sv
rtl/core/b64d_in_stage.sv
rtl/core/b64d_step.sv
rtl/core/b64d_out_stage.sv
rtl/core/base64_stream_decoder.sv
sim/tb_top.sv
